FILE: sv/sps_pkg.sv
// Package for the sorted priority stack: default sizes, command and error codes,
// and the per-cycle control struct shared by the top level and the cells.
// No dependencies.
`default_nettype none

package sps_pkg;

    localparam int DEPTH_DEF          = 16;
    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int PRIORITY_WIDTH_DEF = 8;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } op_error_t;

    // Broadcast to every cell in the cycle a transaction is accepted.
    typedef struct packed {
        logic push_en;
        logic pop_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/sps_cell.sv
// One slot of the sorted priority stack: holds an element and its priority,
// and shifts with its neighbors on push and pop. Depends on sps_pkg.
`default_nettype none

module sps_cell
    import sps_pkg::*;
#(
    parameter int IDX            = 0,
    parameter int CNT_W          = 5,
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
    input  wire                      aclk,
    input  wire cell_ctrl_t          ctrl,
    input  wire [CNT_W-1:0]          count,
    input  wire [VALUE_WIDTH-1:0]    push_value,
    input  wire [PRIORITY_WIDTH-1:0] push_priority,
    input  wire                      left_keep,
    input  wire [VALUE_WIDTH-1:0]    left_value,
    input  wire [PRIORITY_WIDTH-1:0] left_priority,
    input  wire [VALUE_WIDTH-1:0]    right_value,
    input  wire [PRIORITY_WIDTH-1:0] right_priority,
    output logic                     keep,
    output logic [VALUE_WIDTH-1:0]   value,
    output logic [PRIORITY_WIDTH-1:0] priority_q
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [VALUE_WIDTH-1:0]    value_reg, value_next;
    logic [PRIORITY_WIDTH-1:0] prio_reg, prio_next;
    logic                      occupied;

    // Keep the slot on push when it is occupied and strictly outranks the new entry.
    assign occupied = (IDX_C < count);
    assign keep     = occupied && (prio_reg > push_priority);

    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.push_en) begin
            if (keep) begin
                value_next = value_reg;
                prio_next  = prio_reg;
            end else if (left_keep) begin
                value_next = push_value;
                prio_next  = push_priority;
            end else begin
                value_next = left_value;
                prio_next  = left_priority;
            end
        end else if (ctrl.pop_en) begin
            value_next = right_value;
            prio_next  = right_priority;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value      = value_reg;
    assign priority_q = prio_reg;

endmodule

`default_nettype wire

FILE: sv/sorted_priority_stack_unit.sv
// Top level of the sorted priority stack: stream handshake, entry count,
// result register and the chain of sps_cell slots. Depends on sps_pkg, sps_cell.
`default_nettype none

// Usage
//   Input stream (s_*): s_tuser carries the command (0 push, 1 pop); s_tdata
//   carries the push element and its priority. A push places the element ahead
//   of every stored entry of lower or equal priority; a pop removes the front.
//   Output stream (m_*): one result transaction per input transaction with the
//   front element and priority after the operation (zero when empty), the
//   entry count, an empty flag and an error code (push dropped when full, pop
//   on empty).
//   Result: registered; it appears in the cycle after the input is accepted.
//   Throughput: one transaction per cycle while results are taken. Every slot
//   compares its priority against the pushed one in parallel and the whole chain
//   shifts in the accept cycle.
//   Stall: a single result register sits on the output; while it holds an
//   untaken result, s_tready is low, and it rises in the cycle m_tready takes
//   that result, so a new transaction can be accepted in the same cycle.
//   Reset: aresetn (synchronous, active low) empties the stack and drops any
//   pending result; slot contents are not cleared, since only slots below the
//   count are ever read.
module sorted_priority_stack_unit
    import sps_pkg::*;
#(
    parameter int DEPTH          = DEPTH_DEF,
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
    localparam int CNT_W         = $clog2(DEPTH + 1),
    localparam int IN_W          = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
    localparam int OUT_RAW_W     = VALUE_WIDTH + PRIORITY_WIDTH + CNT_W + 3,
    localparam int OUT_W         = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    // push_value, push_priority, zero fill
    input  wire [IN_W-1:0]   s_tdata,
    // cmd
    input  wire              s_tuser,
    output logic             m_tvalid,
    input  wire              m_tready,
    // front_value, front_priority, entry_count, is_empty, op_error, zero fill
    output logic [OUT_W-1:0] m_tdata
);

    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);

    logic [VALUE_WIDTH-1:0]    push_value;
    logic [PRIORITY_WIDTH-1:0] push_priority;
    logic                      accept;
    logic                      is_pop;
    logic                      push_ok;
    logic                      pop_ok;
    cell_ctrl_t                ctrl;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             res_valid_reg, res_valid_next;
    op_error_t        err_reg, err_next;

    logic [VALUE_WIDTH-1:0]    cell_value [DEPTH];
    logic [PRIORITY_WIDTH-1:0] cell_prio  [DEPTH];
    logic                      cell_keep  [DEPTH];

    assign push_value    = s_tdata[VALUE_WIDTH-1:0];
    assign push_priority = s_tdata[VALUE_WIDTH +: PRIORITY_WIDTH];
    assign is_pop        = (s_tuser == CMD_POP);

    // Accept while the result register is free or being emptied this cycle.
    assign s_tready = !res_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign push_ok  = accept && !is_pop && (count_reg != FULL_C);
    assign pop_ok   = accept && is_pop && (count_reg != '0);

    assign ctrl.push_en = push_ok;
    assign ctrl.pop_en  = pop_ok;

    // Count and result bookkeeping.
    always_comb begin
        count_next     = count_reg;
        err_next       = err_reg;
        res_valid_next = res_valid_reg;
        if (m_tready) begin
            res_valid_next = 1'b0;
        end
        if (accept) begin
            res_valid_next = 1'b1;
            if (push_ok) begin
                count_next = count_reg + CNT_W'(1);
                err_next   = ERR_OK;
            end else if (pop_ok) begin
                count_next = count_reg - CNT_W'(1);
                err_next   = ERR_OK;
            end else if (is_pop) begin
                err_next = ERR_EMPTY;
            end else begin
                err_next = ERR_FULL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            err_reg       <= ERR_OK;
        end else begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            err_reg       <= err_next;
        end
    end

    // Slot chain: slot 0 is the front; push shifts toward the back, pop toward the front.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                      l_keep;
        logic [VALUE_WIDTH-1:0]    l_value, r_value;
        logic [PRIORITY_WIDTH-1:0] l_prio, r_prio;

        if (i == 0) begin : g_first
            assign l_keep  = 1'b1;
            assign l_value = push_value;
            assign l_prio  = push_priority;
        end else begin : g_mid
            assign l_keep  = cell_keep[i-1];
            assign l_value = cell_value[i-1];
            assign l_prio  = cell_prio[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_value = cell_value[i];
            assign r_prio  = cell_prio[i];
        end else begin : g_inner
            assign r_value = cell_value[i+1];
            assign r_prio  = cell_prio[i+1];
        end

        sps_cell #(
            .IDX            (i),
            .CNT_W          (CNT_W),
            .VALUE_WIDTH    (VALUE_WIDTH),
            .PRIORITY_WIDTH (PRIORITY_WIDTH)
        ) u_cell (
            .aclk           (aclk),
            .ctrl           (ctrl),
            .count          (count_reg),
            .push_value     (push_value),
            .push_priority  (push_priority),
            .left_keep      (l_keep),
            .left_value     (l_value),
            .left_priority  (l_prio),
            .right_value    (r_value),
            .right_priority (r_prio),
            .keep           (cell_keep[i]),
            .value          (cell_value[i]),
            .priority_q     (cell_prio[i])
        );
    end

    // The slots only change on accept, which also loads the result, so the
    // front slot always matches the pending result.
    logic                      empty;
    logic [VALUE_WIDTH-1:0]    front_value;
    logic [PRIORITY_WIDTH-1:0] front_prio;

    assign empty       = (count_reg == '0);
    assign front_value = empty ? '0 : cell_value[0];
    assign front_prio  = empty ? '0 : cell_prio[0];

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = OUT_W'({err_reg, empty, count_reg, front_prio, front_value});

    // Checks
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_C)
        else $error("entry count exceeds depth");

    a_push_count : assert property (@(posedge aclk) disable iff (!aresetn)
        push_ok |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not advance the count");

    a_pop_count : assert property (@(posedge aclk) disable iff (!aresetn)
        pop_ok |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not drop the count");

    a_push_front : assert property (@(posedge aclk) disable iff (!aresetn)
        push_ok |=> cell_prio[0] >= $past(push_priority))
        else $error("front priority below a freshly pushed priority");

    a_err_drop : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !push_ok && !pop_ok) |=> ($stable(count_reg) && err_reg != ERR_OK))
        else $error("rejected operation changed the count or reported ok");

endmodule

`default_nettype wire

FILE: sim/sorted_priority_stack_unit_tb.sv
// Self-checking testbench for sorted_priority_stack_unit: directed and random push/pop
// traffic with random idling on both streams, checked against an in-bench stack model.
// Depends on sps_pkg and the sorted_priority_stack_unit RTL.
`default_nettype none

module sorted_priority_stack_unit_tb
    import sps_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int IN_W        = 40;
    localparam int OUT_W       = 48;
    localparam int RANDOM_OPS  = 1450;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] value;
        logic [7:0]  prio;
        bit          drain;   // hold this transaction until all results are back
        int          gap;     // idle cycles after this transaction is taken
    } stack_op_t;

    typedef struct {
        logic [31:0] front_value;
        logic [7:0]  front_prio;
        logic [4:0]  entry_count;
        logic        is_empty;
        op_error_t   op_error;
    } front_report_t;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    // push_value, push_priority
    logic [IN_W-1:0] s_tdata  = '0;
    // cmd
    logic            s_tuser  = CMD_PUSH;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    // front_value, front_priority, entry_count, is_empty, op_error
    logic [OUT_W-1:0] m_tdata;

    sorted_priority_stack_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Stack model state: slot 0 is the front, highest priority first.
    logic [31:0] stack_val [STACK_DEPTH];
    logic [7:0]  stack_prio[STACK_DEPTH];
    int          stack_fill = 0;

    stack_op_t     pending_ops[$];
    front_report_t front_reports[$];
    int            sent_count  = 0;
    int            taken_count = 0;
    int            error_count = 0;

    // Apply one operation to the model and return the report the block owes.
    function automatic front_report_t stack_apply(stack_op_t op);
        front_report_t rep;
        int            pos;
        rep.op_error = ERR_OK;
        if (op.cmd == CMD_PUSH) begin
            if (stack_fill == STACK_DEPTH) begin
                rep.op_error = ERR_FULL;
            end else begin
                // Insert ahead of every entry with lower or equal priority (LIFO ties).
                pos = 0;
                while (pos < stack_fill && stack_prio[pos] > op.prio)
                    pos++;
                for (int k = stack_fill; k > pos; k--) begin
                    stack_val[k]  = stack_val[k-1];
                    stack_prio[k] = stack_prio[k-1];
                end
                stack_val[pos]  = op.value;
                stack_prio[pos] = op.prio;
                stack_fill++;
            end
        end else if (stack_fill == 0) begin
            rep.op_error = ERR_EMPTY;
        end else begin
            for (int k = 0; k + 1 < stack_fill; k++) begin
                stack_val[k]  = stack_val[k+1];
                stack_prio[k] = stack_prio[k+1];
            end
            stack_fill--;
        end
        if (stack_fill != 0) begin
            rep.front_value = stack_val[0];
            rep.front_prio  = stack_prio[0];
            rep.is_empty    = 1'b0;
        end else begin
            rep.front_value = '0;
            rep.front_prio  = '0;
            rep.is_empty    = 1'b1;
        end
        rep.entry_count = 5'(stack_fill);
        return rep;
    endfunction

    // Idle length: mostly none or short, now and then long; none in quiet stretches.
    function automatic int idle_len(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic stack_op_t make_op(cmd_t cmd, logic [31:0] value, logic [7:0] prio,
                                          bit drain, int gap);
        stack_op_t op;
        op.cmd   = cmd;
        op.value = value;
        op.prio  = prio;
        op.drain = drain;
        op.gap   = gap;
        return op;
    endfunction

    task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name,
                     exp_v, act_v);
            error_count++;
        end
    endtask

    // Driver: present queued operations, honor per-transaction gaps and drain holds.
    stack_op_t next_op;
    int        hold_cnt = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                front_reports.push_back(stack_apply(make_op(cmd_t'(s_tuser), s_tdata[31:0],
                                                            s_tdata[39:32], 1'b0, 0)));
                sent_count <= sent_count + 1;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transaction until it is taken
            end else if (hold_cnt != 0) begin
                s_tvalid <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end else if (pending_ops.size() != 0 &&
                         (!pending_ops[0].drain ||
                          (sent_count == taken_count && !(s_tvalid && s_tready)))) begin
                next_op  = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {next_op.prio, next_op.value};
                s_tuser  <= next_op.cmd;
                hold_cnt <= next_op.gap;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random back-pressure, compare each result with the oldest expectation.
    int            stall_cnt = 0;
    bit            sink_quiet = 1'b0;
    front_report_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                taken_count <= taken_count + 1;
                if (front_reports.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = front_reports.pop_front();
                    report_field("front_value", want.front_value, m_tdata[31:0]);
                    report_field("front_priority", 32'(want.front_prio), 32'(m_tdata[39:32]));
                    report_field("entry_count", 32'(want.entry_count), 32'(m_tdata[44:40]));
                    report_field("is_empty", 32'(want.is_empty), 32'(m_tdata[45]));
                    report_field("op_error", 32'(want.op_error), 32'(m_tdata[47:46]));
                end
                // Switch between quiet and stalling stretches now and then.
                if ($urandom_range(0, 63) == 0)
                    sink_quiet <= ($urandom_range(0, 2) == 0);
            end
            if (stall_cnt != 0) begin
                m_tready  <= 1'b0;
                stall_cnt <= stall_cnt - 1;
            end else begin
                m_tready  <= 1'b1;
                stall_cnt <= idle_len(sink_quiet);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("sorted_priority_stack_unit_tb failed");
        $finish;
    end

    // Stimulus and end of run.
    initial begin
        int          push_pct;
        int          prio_mode;
        int          run_len;
        int          made;
        int          total_ops;
        bit          quiet;
        logic [31:0] val;
        logic [7:0]  pr;

        // Directed: empty pop, field extremes, ties at top and bottom, drain back to empty.
        pending_ops.push_back(make_op(CMD_POP, 32'h0, 8'h0, 1'b0, 0));
        pending_ops.push_back(make_op(CMD_PUSH, 32'h0000_0000, 8'h00, 1'b0, 0));
        pending_ops.push_back(make_op(CMD_PUSH, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1));
        pending_ops.push_back(make_op(CMD_PUSH, 32'h1234_5678, 8'hFF, 1'b0, 0));
        pending_ops.push_back(make_op(CMD_POP, 32'hFFFF_FFFF, 8'hFF, 1'b0, 0));
        pending_ops.push_back(make_op(CMD_PUSH, 32'hA5A5_A5A5, 8'h00, 1'b0, 0));
        pending_ops.push_back(make_op(CMD_PUSH, 32'h5A5A_5A5A, 8'h80, 1'b1, 0));
        pending_ops.push_back(make_op(CMD_PUSH, 32'hDEAD_BEEF, 8'h7F, 1'b0, 2));
        pending_ops.push_back(make_op(CMD_PUSH, 32'h0F0F_0F0F, 8'h80, 1'b0, 0));
        for (int i = 0; i < 7; i++)
            pending_ops.push_back(make_op(CMD_POP, $urandom, 8'($urandom), 1'b0, i % 2));
        pending_ops.push_back(make_op(CMD_POP, 32'h0, 8'h0, 1'b1, 0));

        // Random: runs biased toward filling, emptying or churning, so the stack
        // sweeps through full and empty repeatedly.
        made = 0;
        while (made < RANDOM_OPS) begin
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            prio_mode = $urandom_range(0, 2);
            run_len   = $urandom_range(20, 60);
            quiet     = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < run_len; i++) begin
                val = $urandom;
                case ($urandom_range(0, 9))
                    0:       val = 32'h0000_0000;
                    1:       val = 32'hFFFF_FFFF;
                    default: ;
                endcase
                case (prio_mode)
                    0:       pr = 8'($urandom_range(0, 3));       // many ties
                    1:       pr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: pr = 8'($urandom);
                endcase
                pending_ops.push_back(make_op(
                    ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP, val, pr,
                    ($urandom_range(0, 149) == 0), idle_len(quiet)));
            end
            made += run_len;
        end
        total_ops = pending_ops.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until a result has come back for every operation.
        do
            @(posedge aclk);
        while (taken_count != total_ops);
        repeat (4) @(posedge aclk);

        if (front_reports.size() != 0) begin
            $display("%0t ns: missing results, expected %0d more, actual none", $time,
                     front_reports.size());
            error_count++;
        end
        if (error_count == 0)
            $display("sorted_priority_stack_unit_tb passed");
        else
            $display("sorted_priority_stack_unit_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
